[rtl/core/circular_byte_queue_with_peek_defines.svh]
// ----------------------------------------------------------------------------
// Circular byte queue assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_BYTE_QUEUE_WITH_PEEK_DEFINES_SVH
`define CIRCULAR_BYTE_QUEUE_WITH_PEEK_DEFINES_SVH

`ifndef SYNTHESIS

`define CBQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cbq assertion failed");

`define CBQ_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("cbq forbidden condition");

`else

`define CBQ_ASSERT(lbl, prop)

`define CBQ_ASSERT_NEVER(lbl, cond)

`endif

`endif

[rtl/core/cbq_pkg.sv]
// ----------------------------------------------------------------------------
// Circular byte queue package
// Word types, command and status codes, controller states and commands.
// ----------------------------------------------------------------------------
`default_nettype none

package cbq_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_PUSH     = 3'd1,
    CMD_POP      = 3'd2,
    CMD_PEEK     = 3'd3,
    CMD_SET_HEAD = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISS     = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BAD_HEAD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] position;
    logic       burst_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic [7:0] fill_level;
    logic [7:0] head_pos;
    logic       is_empty;
    logic       is_full;
    logic [7:0] written_count;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic read_en;
    logic commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/core/cbq_ctrl.sv]
// ----------------------------------------------------------------------------
// Circular byte queue controller
// Sequences accept, storage read and commit; owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_byte_queue_with_peek_defines.svh"

module cbq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output cbq_pkg::dp_cmd_t     dp_cmd_o
);
  import cbq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o       = 1'b1;
    dp_cmd_o.load_in = 1'b0;
    dp_cmd_o.read_en = 1'b0;
    dp_cmd_o.commit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o       = 1'b0;
        dp_cmd_o.load_in = in_valid_i;
      end
      S_READ: begin
        dp_cmd_o.read_en = 1'b1;
      end
      S_COMMIT: begin
        dp_cmd_o.commit = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (dp_cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `CBQ_ASSERT(a_accept_then_read, accept |=> state_q == S_READ)
  `CBQ_ASSERT_NEVER(a_commit_over_stalled, dp_cmd_o.commit && out_valid_q && out_stall_i)
  `CBQ_ASSERT(a_valid_rise_after_commit, $rose(out_valid_q) |-> $past(dp_cmd_o.commit))

endmodule

`default_nettype wire

[rtl/core/cbq_dp.sv]
// ----------------------------------------------------------------------------
// Circular byte queue datapath
// Storage, head and tail pointers, burst counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbq_dp #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cbq_pkg::dp_cmd_t  dp_cmd_i,
  input  wire cbq_pkg::in_word_t in_word_i,
  output cbq_pkg::out_word_t     out_word_o
);
  import cbq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [AW:0]   DepthW  = (AW + 1)'(DEPTH);

  logic [7:0]    mem_q [DEPTH];
  in_word_t      in_q;
  out_word_t     out_q, out_d;
  logic [AW-1:0] pos_q, pos_mod;
  logic [7:0]    rd_data_q;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [7:0]    burst_q, burst_d;
  logic [AW-1:0] rd_addr, head_inc, tail_inc, tail_d_inc;
  logic          wr_en, empty_now, full_now, span_excl, span_incl;
  logic [1:0]    status;
  logic [7:0]    data, wcount;
  logic [AW:0]   fill_w;
  logic [AW+7:0] fill_x, head_x;
  logic [7:0]    red;

  always_comb begin
    red = in_q.position;
    for (int k = 7; k >= 0; k--) begin
      if ({24'd0, red} >= (32'(DEPTH) << k)) red = red - 8'(32'(DEPTH) << k);
    end
    pos_mod = AW'(red);
  end

  assign head_inc   = (head_q == LastIdx) ? '0 : head_q + AW'(1);
  assign tail_inc   = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
  assign empty_now  = head_q == tail_q;
  assign full_now   = head_q == tail_inc;
  assign rd_addr    = (in_q.cmd == CMD_POP) ? head_q : pos_mod;

  always_comb begin
    if (head_q < tail_q) begin
      span_excl = (pos_q >= head_q) && (pos_q < tail_q);
      span_incl = (pos_q >= head_q) && (pos_q <= tail_q);
    end else begin
      span_excl = (pos_q >= head_q) || (pos_q < tail_q);
      span_incl = (pos_q >= head_q) || (pos_q <= tail_q);
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    burst_d = burst_q;
    status  = STAT_OK;
    data    = '0;
    wcount  = '0;
    wr_en   = 1'b0;
    unique case (in_q.cmd)
      CMD_CLEAR: begin
        head_d = '0;
        tail_d = '0;
      end
      CMD_PUSH: begin
        if (full_now) begin
          status = STAT_FULL;
        end else begin
          wr_en  = 1'b1;
          tail_d = tail_inc;
          if (burst_q != 8'hFF) burst_d = burst_q + 8'd1;
        end
        if (in_q.burst_last) begin
          wcount  = burst_d;
          burst_d = '0;
        end
      end
      CMD_POP: begin
        if (empty_now) begin
          status = STAT_MISS;
        end else begin
          data   = rd_data_q;
          head_d = head_inc;
        end
      end
      CMD_PEEK: begin
        if (!empty_now && span_excl) begin
          data = rd_data_q;
        end else begin
          status = STAT_MISS;
        end
      end
      CMD_SET_HEAD: begin
        if (!empty_now) begin
          if (span_incl) begin
            head_d = pos_q;
          end else begin
            head_d = '0;
            tail_d = '0;
            status = STAT_BAD_HEAD;
          end
        end
      end
      default: begin
        status = STAT_OK;
      end
    endcase
  end

  assign tail_d_inc = (tail_d == LastIdx) ? '0 : tail_d + AW'(1);

  always_comb begin
    fill_w = {1'b0, tail_d} - {1'b0, head_d};
    if (tail_d < head_d) fill_w = fill_w + DepthW;
    fill_x = (AW + 8)'(fill_w[AW-1:0]);
    head_x = (AW + 8)'(head_d);
    out_d.status        = status;
    out_d.data_out      = data;
    out_d.fill_level    = fill_x[7:0];
    out_d.head_pos      = head_x[7:0];
    out_d.is_empty      = head_d == tail_d;
    out_d.is_full       = head_d == tail_d_inc;
    out_d.written_count = wcount;
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_in) in_q <= in_word_i;
    if (dp_cmd_i.read_en) begin
      pos_q     <= pos_mod;
      rd_data_q <= mem_q[rd_addr];
    end
    if (dp_cmd_i.commit) out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.commit && wr_en) mem_q[tail_q] <= in_q.data_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      burst_q <= '0;
    end else if (dp_cmd_i.commit) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      burst_q <= burst_d;
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

[rtl/core/circular_byte_queue_with_peek.sv]
// Each command word passes through the accept, storage read and commit states;
// the queue takes a new command word only after the last one has committed.
// A finished result waits in the output register; the next word is taken
// meanwhile, and its commit holds while that result is stalled.
// Reset clears head, tail, burst count and the output valid flag; storage is not reset.
// ----------------------------------------------------------------------------
// Circular byte queue with peek
// Byte ring buffer with push, pop, peek, set head and burst counting.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_byte_queue_with_peek #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire cbq_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output cbq_pkg::out_word_t      out_word_o
);
  import cbq_pkg::*;

  dp_cmd_t dp_cmd;

  cbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd)
  );

  cbq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dp_cmd_i   (dp_cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

[tb/sv/cbq_monitor.sv]
// ----------------------------------------------------------------------------
// Circular byte queue response monitor
// Watches the command and response channels of the byte queue, keeps its own
// copy of the pointers, burst count and byte store, works out the response
// word for every accepted command and compares each accepted response with
// the oldest one still awaited.
// ----------------------------------------------------------------------------
module cbq_monitor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  cbq_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  cbq_pkg::out_word_t out_word_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cbq_pkg::*;

  logic [7:0]  q_mem [256];
  logic [7:0]  q_head;
  logic [7:0]  q_tail;
  logic [7:0]  q_burst;
  out_word_t   awaited[$];
  out_word_t   want;
  int unsigned fails = 0;
  int unsigned checked = 0;

  initial begin
    foreach (q_mem[i]) q_mem[i] = '0;
  end

  function automatic logic in_occupied(input logic [7:0] p, input logic tail_counts);
    logic below_tail;
    below_tail = tail_counts ? (p <= q_tail) : (p < q_tail);
    if (q_head < q_tail) return (p >= q_head) && below_tail;
    return (p >= q_head) || below_tail;
  endfunction

  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t r;
    logic      was_empty;
    r = '0;
    was_empty = (q_head == q_tail);
    case (w.cmd)
      CMD_CLEAR: begin
        q_head = '0;
        q_tail = '0;
      end
      CMD_PUSH: begin
        if (q_head == q_tail + 8'd1) begin
          r.status = STAT_FULL;
        end else begin
          q_mem[q_tail] = w.data_byte;
          q_tail = q_tail + 8'd1;
          if (q_burst != 8'hFF) q_burst = q_burst + 8'd1;
        end
        if (w.burst_last) begin
          r.written_count = q_burst;
          q_burst = '0;
        end
      end
      CMD_POP: begin
        if (was_empty) begin
          r.status = STAT_MISS;
        end else begin
          r.data_out = q_mem[q_head];
          q_head = q_head + 8'd1;
        end
      end
      CMD_PEEK: begin
        if (!was_empty && in_occupied(w.position, 1'b0)) begin
          r.data_out = q_mem[w.position];
        end else begin
          r.status = STAT_MISS;
        end
      end
      CMD_SET_HEAD: begin
        if (!was_empty) begin
          if (in_occupied(w.position, 1'b1)) begin
            q_head = w.position;
          end else begin
            q_head = '0;
            q_tail = '0;
            r.status = STAT_BAD_HEAD;
          end
        end
      end
      default: begin
      end
    endcase
    r.fill_level = q_tail - q_head;
    r.head_pos   = q_head;
    r.is_empty   = (q_head == q_tail);
    r.is_full    = (q_head == q_tail + 8'd1);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_head = '0;
      q_tail = '0;
      q_burst = '0;
      awaited.delete();
      pending_o <= 0;
      fail_count_o <= fails;
      checked_o <= checked;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: response with no command awaiting it: %h", $realtime, out_word_i);
          end
          fails++;
        end else begin
          want = awaited.pop_front();
          checked++;
          if (out_word_i.status !== want.status || out_word_i.data_out !== want.data_out ||
              out_word_i.fill_level !== want.fill_level ||
              out_word_i.head_pos !== want.head_pos ||
              out_word_i.is_empty !== want.is_empty || out_word_i.is_full !== want.is_full ||
              out_word_i.written_count !== want.written_count) begin
            if (fails < 10) begin
              $display("%0t: response %0d mismatch (expected / actual)", $realtime, checked);
              $display("  status %0d / %0d  data %02h / %02h  fill %0d / %0d  head %0d / %0d",
                       want.status, out_word_i.status, want.data_out, out_word_i.data_out,
                       want.fill_level, out_word_i.fill_level,
                       want.head_pos, out_word_i.head_pos);
              $display("  empty %b / %b  full %b / %b  count %0d / %0d",
                       want.is_empty, out_word_i.is_empty, want.is_full, out_word_i.is_full,
                       want.written_count, out_word_i.written_count);
            end
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) awaited.push_back(apply_command(in_word_i));
      pending_o <= awaited.size();
      fail_count_o <= fails;
      checked_o <= checked;
    end
  end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Circular byte queue testbench
// Drives directed corner commands and then long runs of push, pop, peek,
// set-head, clear and reserved-code traffic with random bytes and positions,
// random gaps and response stalls; the monitor predicts and checks every response word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbq_pkg::*;

  localparam logic [2:0]  CMD_RSVD_A = 3'd5;
  localparam logic [2:0]  CMD_RSVD_B = 3'd6;
  localparam logic [2:0]  CMD_RSVD_C = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_WORDS = 900;
  localparam int          MODE_MIX = 0;
  localparam int          MODE_FILL = 1;
  localparam int          MODE_DRAIN = 2;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned cmd_seen [8];
  logic        calm = 1'b0;
  logic [7:0]  hd = '0;
  logic [7:0]  tl = '0;

  circular_byte_queue_with_peek #(.DEPTH(256)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  cbq_monitor u_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !calm && ($urandom_range(0, 99) < 12);
    end
  end

  function automatic in_word_t make_word(input logic [2:0] c, input logic [7:0] d,
                                         input logic [7:0] p, input logic l);
    in_word_t w;
    w.cmd = c;
    w.data_byte = d;
    w.position = p;
    w.burst_last = l;
    return w;
  endfunction

  task automatic issue_command(input in_word_t w);
    logic [7:0] off;
    logic [7:0] span;
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    cmd_seen[w.cmd]++;
    // track pointers for picking positions
    off = w.position - hd;
    span = tl - hd;
    case (w.cmd)
      CMD_CLEAR: begin
        hd = '0;
        tl = '0;
      end
      CMD_PUSH: if (tl + 8'd1 != hd) tl = tl + 8'd1;
      CMD_POP: if (hd != tl) hd = hd + 8'd1;
      CMD_SET_HEAD: begin
        if (hd != tl) begin
          if (off <= span) begin
            hd = w.position;
          end else begin
            hd = '0;
            tl = '0;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic wait_for_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_block(input int mode, input int len);
    int         r;
    int         push_w;
    int         pop_w;
    logic [2:0] c;
    logic [7:0] p;
    logic [7:0] span;
    case (mode)
      MODE_FILL: begin
        push_w = 58;
        pop_w = 12;
      end
      MODE_DRAIN: begin
        push_w = 14;
        pop_w = 56;
      end
      default: begin
        push_w = 38;
        pop_w = 32;
      end
    endcase
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < push_w) c = CMD_PUSH;
      else if (r < 70) c = CMD_POP;
      else if (r < 88) c = CMD_PEEK;
      else if (r < 96) c = CMD_SET_HEAD;
      else if (r < 97) c = CMD_CLEAR;
      else if (r < 98) c = CMD_RSVD_A;
      else if (r < 99) c = CMD_RSVD_B;
      else c = CMD_RSVD_C;
      p = 8'($urandom);
      span = tl - hd;
      if ((c == CMD_PEEK || c == CMD_SET_HEAD) && span != 0 && $urandom_range(0, 99) < 75) begin
        p = hd + 8'($urandom_range(0, (c == CMD_SET_HEAD) ? span : span - 1));
      end
      issue_command(make_word(c, 8'($urandom), p, $urandom_range(0, 5) == 0));
    end
  endtask

  task automatic fill_past_capacity();
    issue_command(make_word(CMD_CLEAR, 8'($urandom), 8'($urandom), 1'b0));
    repeat (258) issue_command(make_word(CMD_PUSH, 8'($urandom), 8'($urandom), 1'b0));
    repeat (4) issue_command(make_word(CMD_PEEK, 8'($urandom), 8'($urandom), 1'($urandom)));
    repeat (12) issue_command(make_word(CMD_POP, 8'($urandom), 8'($urandom), 1'b0));
    repeat (11) issue_command(make_word(CMD_PUSH, 8'($urandom), 8'($urandom), 1'b0));
    issue_command(make_word(CMD_PUSH, 8'($urandom), 8'($urandom), 1'b1));
  endtask

  initial begin
    int unsigned target;
    logic        saturated;
    saturated = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_command(make_word(CMD_CLEAR, 8'h00, 8'h00, 1'b1));
    issue_command(make_word(CMD_POP, 8'hFF, 8'hFF, 1'b1));
    issue_command(make_word(CMD_PEEK, 8'h00, 8'h00, 1'b0));
    issue_command(make_word(CMD_SET_HEAD, 8'h00, 8'h07, 1'b0));
    issue_command(make_word(CMD_PUSH, 8'h00, 8'hFF, 1'b0));
    issue_command(make_word(CMD_PUSH, 8'hFF, 8'h00, 1'b0));
    issue_command(make_word(CMD_PUSH, 8'h5A, 8'hA5, 1'b1));
    issue_command(make_word(CMD_PEEK, 8'h00, 8'h00, 1'b0));
    issue_command(make_word(CMD_PEEK, 8'h00, 8'h02, 1'b0));
    issue_command(make_word(CMD_PEEK, 8'h00, 8'h03, 1'b0));
    issue_command(make_word(CMD_PEEK, 8'h00, 8'hFF, 1'b1));
    issue_command(make_word(CMD_POP, 8'h00, 8'h00, 1'b0));
    issue_command(make_word(CMD_PEEK, 8'h00, 8'h00, 1'b0));
    issue_command(make_word(CMD_SET_HEAD, 8'h00, 8'h03, 1'b0));
    issue_command(make_word(CMD_PUSH, 8'hA5, 8'h00, 1'b0));
    issue_command(make_word(CMD_PUSH, 8'h3C, 8'h00, 1'b1));
    issue_command(make_word(CMD_SET_HEAD, 8'h00, 8'hC8, 1'b1));
    issue_command(make_word(CMD_RSVD_A, 8'hFF, 8'hFF, 1'b1));
    issue_command(make_word(CMD_RSVD_B, 8'h00, 8'h00, 1'b0));
    issue_command(make_word(CMD_RSVD_C, 8'h81, 8'h7E, 1'b1));
    issue_command(make_word(CMD_PUSH, 8'h81, 8'h00, 1'b1));
    issue_command(make_word(CMD_POP, 8'h00, 8'h00, 1'b0));
    issue_command(make_word(CMD_POP, 8'h00, 8'h00, 1'b0));
    issue_command(make_word(CMD_CLEAR, 8'h00, 8'h00, 1'b0));
    wait_for_responses();

    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      if (!saturated && words_sent + 600 > target) begin
        fill_past_capacity();
        saturated = 1'b1;
      end
      calm = (words_sent + 350 > target) && (words_sent + 200 < target);
      run_block($urandom_range(MODE_MIX, MODE_DRAIN), $urandom_range(20, 60));
      if ($urandom_range(0, 7) == 0) wait_for_responses();
    end
    calm = 1'b0;

    wait_for_responses();
    repeat (20) @(posedge clk);
    $display("covered %0d words: %0d clear, %0d push, %0d pop, %0d peek, %0d set head, %0d spare",
             words_sent, cmd_seen[CMD_CLEAR], cmd_seen[CMD_PUSH], cmd_seen[CMD_POP],
             cmd_seen[CMD_PEEK], cmd_seen[CMD_SET_HEAD],
             cmd_seen[CMD_RSVD_A] + cmd_seen[CMD_RSVD_B] + cmd_seen[CMD_RSVD_C]);
    $display("%0d responses checked, including a fill to capacity with a saturated burst count",
             checked);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
